FILE: hdl/rlmc_pkg.sv
`timescale 1ns / 1ps
package rlmc_pkg;

  localparam int MaxAct = 5;
  localparam int QDepth = 2;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_PKT  = 2'd2;

  localparam logic [2:0] M_INIT   = 3'd0;
  localparam logic [2:0] M_OFF    = 3'd1;
  localparam logic [2:0] M_ON     = 3'd2;
  localparam logic [2:0] M_DOCK   = 3'd3;
  localparam logic [2:0] M_CLEAN  = 3'd4;
  localparam logic [2:0] M_WAKEHI = 3'd5;
  localparam logic [2:0] M_WAKELO = 3'd6;

  localparam logic [2:0] R_NONE  = 3'd0;
  localparam logic [2:0] R_OFF   = 3'd1;
  localparam logic [2:0] R_ON    = 3'd2;
  localparam logic [2:0] R_DOCK  = 3'd3;
  localparam logic [2:0] R_CLEAN = 3'd4;
  localparam logic [2:0] R_MAX   = 3'd5;
  localparam logic [2:0] R_RESET = 3'd6;

  localparam logic [3:0] A_START  = 4'd0;
  localparam logic [3:0] A_POWER  = 4'd1;
  localparam logic [3:0] A_CLEAN  = 4'd2;
  localparam logic [3:0] A_MAX    = 4'd3;
  localparam logic [3:0] A_DOCK   = 4'd4;
  localparam logic [3:0] A_RESET  = 4'd5;
  localparam logic [3:0] A_SENSOR = 4'd6;
  localparam logic [3:0] A_WAKEHI = 4'd7;
  localparam logic [3:0] A_WAKELO = 4'd8;
  localparam logic [3:0] A_STATUS = 4'd9;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_STEP    = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;

  localparam logic [7:0] TIMEOUT_RST = 8'd5;
  localparam logic [7:0] STEP_RST    = 8'd10;
  localparam logic [7:0] LIMIT_RST   = 8'd150;

  typedef struct packed {
    logic [7:0] reply_timeout_ticks;
    logic [7:0] fault_step;
    logic [7:0] fault_limit;
  } cfg_t;

  typedef struct packed {
    logic [MaxAct-1:0][3:0] acts;
    logic [2:0]             n;
  } act_list_t;

  typedef struct packed {
    act_list_t    cmds;
    logic [2:0]   mode;
    logic         link;
    logic [31:0]  dsum;
    logic [31:0]  asum;
    logic [7:0]   fault;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic act_list_t push_act(act_list_t l, logic [3:0] a);
    act_list_t r;
    r = l;
    if (r.n < 3'(MaxAct)) begin
      r.acts[r.n] = a;
      r.n = r.n + 3'd1;
    end
    return r;
  endfunction

endpackage

FILE: hdl/rlmc_queue.sv
`timescale 1ns / 1ps
module rlmc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rlmc_pkg::q_entry_t push_data,
  input  logic               pop,
  output rlmc_pkg::q_entry_t head,
  output rlmc_pkg::q_status_t stat
);
  import rlmc_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  q_entry_t          mem_r [QDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == CntW'(QDepth));
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue pop while empty");
`endif

endmodule

FILE: hdl/rlmc_front.sv
`timescale 1ns / 1ps
module rlmc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  rlmc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [2:0]          in_requested_mode,
  input  logic signed [15:0]  in_distance_delta,
  input  logic signed [15:0]  in_angle_delta,
  input  rlmc_pkg::q_status_t qstat,
  output logic                push,
  output rlmc_pkg::q_entry_t  push_data
);
  import rlmc_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        aw_r, aw_nxt;
  logic [7:0]  cd_r, cd_nxt;
  logic [7:0]  fault_r, fault_nxt;
  logic        link_r, link_nxt;
  logic        fresh_r, fresh_nxt;
  logic [31:0] dist_r, dist_nxt;
  logic [31:0] ang_r, ang_nxt;

  act_list_t   acts;
  logic [2:0]  p;
  logic [8:0]  fsum;
  logic        po;
  logic        take;

  assign in_ready = !qstat.full;
  assign take     = in_valid && in_ready;
  assign push     = take;

  always_comb begin
    mode_nxt  = mode_r;
    step_nxt  = step_r;
    pend_nxt  = pend_r;
    aw_nxt    = aw_r;
    cd_nxt    = cd_r;
    fault_nxt = fault_r;
    link_nxt  = link_r;
    fresh_nxt = fresh_r;
    dist_nxt  = dist_r;
    ang_nxt   = ang_r;
    acts      = '0;
    p         = pend_r;
    fsum      = '0;
    po        = 1'b0;
    if (take) begin
      case (in_op)
        OP_TICK: begin
          if (cd_nxt != 8'd0) begin
            cd_nxt = cd_nxt - 8'd1;
            if (cd_nxt == 8'd0) begin
              aw_nxt    = 1'b0;
              fsum      = {1'b0, fault_nxt} + {1'b0, cfg.fault_step};
              fault_nxt = fsum[8] ? 8'hFF : fsum[7:0];
            end
          end
          if (p == R_RESET) begin
            acts     = push_act(acts, A_RESET);
            step_nxt = 3'd0;
            pend_nxt = R_NONE;
            mode_nxt = M_ON;
            p        = R_NONE;
          end
          if (fault_nxt >= cfg.fault_limit) begin
            link_nxt = 1'b0;
            acts     = push_act(acts, A_POWER);
            step_nxt = 3'd0;
          end
          case (mode_nxt)
            M_INIT: begin
              case (step_nxt)
                3'd0: begin
                  acts     = push_act(acts, A_START);
                  step_nxt = 3'd1;
                end
                3'd1: begin
                  if (!aw_nxt) begin
                    aw_nxt = 1'b1;
                    cd_nxt = cfg.reply_timeout_ticks;
                    acts   = push_act(acts, A_SENSOR);
                  end
                  fresh_nxt = 1'b0;
                  step_nxt  = 3'd2;
                end
                3'd2, 3'd3, 3'd4: begin
                  step_nxt = step_nxt + 3'd1;
                  if (fresh_nxt) begin
                    step_nxt  = 3'd0;
                    mode_nxt  = M_ON;
                    fault_nxt = 8'd0;
                    link_nxt  = 1'b1;
                  end
                end
                3'd5: po = 1'b1;
                default: ;
              endcase
            end
            M_ON: begin
              if (p == R_ON) begin
                pend_nxt = R_NONE;
              end else if (p == R_OFF) begin
                po = 1'b1;
              end else if (p == R_CLEAN || p == R_MAX || p == R_DOCK) begin
                acts = push_act(acts, (p == R_CLEAN) ? A_CLEAN :
                                      (p == R_MAX) ? A_MAX : A_DOCK);
                step_nxt = 3'd0;
                pend_nxt = R_NONE;
                mode_nxt = (p == R_DOCK) ? M_DOCK : M_CLEAN;
              end
            end
            M_OFF: begin
              if (p == R_OFF) begin
                pend_nxt = R_NONE;
              end else if (p inside {R_ON, R_CLEAN, R_MAX, R_DOCK}) begin
                mode_nxt = M_WAKEHI;
              end
            end
            M_CLEAN: begin
              if (p == R_OFF) begin
                po = 1'b1;
              end else if (p == R_ON) begin
                acts     = push_act(acts, A_CLEAN);
                step_nxt = 3'd0;
                pend_nxt = R_NONE;
                mode_nxt = M_ON;
              end else if (p == R_MAX || p == R_DOCK) begin
                acts     = push_act(acts, (p == R_MAX) ? A_MAX : A_DOCK);
                acts     = push_act(acts, (p == R_MAX) ? A_MAX : A_DOCK);
                step_nxt = 3'd0;
                pend_nxt = R_NONE;
                mode_nxt = (p == R_MAX) ? M_CLEAN : M_DOCK;
              end else if (p == R_CLEAN) begin
                pend_nxt = R_NONE;
              end
            end
            M_DOCK: begin
              if (p == R_OFF) begin
                po = 1'b1;
              end else if (p == R_ON) begin
                acts     = push_act(acts, A_DOCK);
                step_nxt = 3'd0;
                pend_nxt = R_NONE;
                mode_nxt = M_ON;
              end else if (p == R_MAX || p == R_CLEAN) begin
                acts     = push_act(acts, (p == R_MAX) ? A_MAX : A_CLEAN);
                acts     = push_act(acts, (p == R_MAX) ? A_MAX : A_CLEAN);
                step_nxt = 3'd0;
                pend_nxt = R_NONE;
                mode_nxt = M_CLEAN;
              end else if (p == R_DOCK) begin
                pend_nxt = R_NONE;
              end
            end
            M_WAKEHI: begin
              acts     = push_act(acts, A_WAKEHI);
              mode_nxt = M_WAKELO;
            end
            M_WAKELO: begin
              acts     = push_act(acts, A_WAKELO);
              step_nxt = 3'd0;
              mode_nxt = M_INIT;
            end
            default: mode_nxt = M_INIT;
          endcase
          if (po) begin
            link_nxt = 1'b0;
            acts     = push_act(acts, A_POWER);
            step_nxt = 3'd0;
            pend_nxt = R_NONE;
            mode_nxt = M_OFF;
          end
          if (link_nxt) begin
            if (!aw_nxt) begin
              aw_nxt = 1'b1;
              cd_nxt = cfg.reply_timeout_ticks;
              acts   = push_act(acts, A_SENSOR);
            end
          end else begin
            dist_nxt = '0;
            ang_nxt  = '0;
          end
        end
        OP_REQ: begin
          if (mode_r >= M_OFF && mode_r <= M_CLEAN) begin
            pend_nxt = in_requested_mode;
          end else begin
            pend_nxt = R_NONE;
          end
        end
        OP_PKT: begin
          if (aw_r) begin
            dist_nxt  = dist_r - {{16{in_distance_delta[15]}}, in_distance_delta};
            ang_nxt   = ang_r + {{16{in_angle_delta[15]}}, in_angle_delta};
            aw_nxt    = 1'b0;
            cd_nxt    = 8'd0;
            fresh_nxt = 1'b1;
            if (fault_r != 8'd0) begin
              fault_nxt = fault_r - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
    push_data.cmds  = acts;
    push_data.mode  = mode_nxt;
    push_data.link  = link_nxt;
    push_data.dsum  = dist_nxt;
    push_data.asum  = ang_nxt;
    push_data.fault = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_INIT;
      step_r  <= 3'd0;
      pend_r  <= R_NONE;
      aw_r    <= 1'b0;
      cd_r    <= 8'd0;
      fault_r <= 8'd0;
      link_r  <= 1'b0;
      fresh_r <= 1'b0;
      dist_r  <= '0;
      ang_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      pend_r  <= pend_nxt;
      aw_r    <= aw_nxt;
      cd_r    <= cd_nxt;
      fault_r <= fault_nxt;
      link_r  <= link_nxt;
      fresh_r <= fresh_nxt;
      dist_r  <= dist_nxt;
      ang_r   <= ang_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_countdown_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    (cd_r != 8'd0) |-> aw_r)
    else $error("reply countdown running with no reply awaited");
  a_link_mode: assert property (@(posedge clk) disable iff (!rst_n)
    link_r |-> (mode_r == M_ON || mode_r == M_DOCK || mode_r == M_CLEAN))
    else $error("link up outside an operating mode");
`endif

endmodule

FILE: hdl/rlmc_back.sv
`timescale 1ns / 1ps
module rlmc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rlmc_pkg::q_entry_t  head,
  input  rlmc_pkg::q_status_t qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_action,
  output logic [2:0]          out_mode,
  output logic                out_link_up,
  output logic signed [31:0]  out_distance_sum,
  output logic signed [31:0]  out_angle_sum,
  output logic [7:0]          out_fault_count,
  output logic                out_last
);
  import rlmc_pkg::*;

  q_entry_t   ent_r, ent_nxt;
  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       at_status;

  assign at_status = (idx_r == ent_r.cmds.n);
  assign pop = !qstat.empty && (!busy_r || (out_ready && at_status));

  always_comb begin
    ent_nxt  = ent_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      ent_nxt  = head;
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (busy_r && out_ready) begin
      if (at_status) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign out_valid        = busy_r;
  assign out_action       = at_status ? A_STATUS : ent_r.cmds.acts[idx_r];
  assign out_mode         = at_status ? ent_r.mode : 3'd0;
  assign out_link_up      = at_status && ent_r.link;
  assign out_distance_sum = at_status ? ent_r.dsum : 32'sd0;
  assign out_angle_sum    = at_status ? ent_r.asum : 32'sd0;
  assign out_fault_count  = at_status ? ent_r.fault : 8'd0;
  assign out_last         = at_status;

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= ent_r.cmds.n))
    else $error("result index past status item");
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_action == A_STATUS))
    else $error("last result is not a status item");
`endif

endmodule

FILE: hdl/robot_link_mode_controller.sv
`timescale 1ns / 1ps
// Mode controller for a serial-linked robot. Each accepted input transaction
// (tick, mode request or sensor packet) is processed by the front end in the
// cycle it is accepted and queued, two entries deep, as a list of command
// actions plus one status result. The back end sends one result per cycle
// while out_ready is high; an input that produces k commands yields k + 1
// results (1 to 4) in all. Inputs are accepted every cycle while the queue
// has room. Configuration registers sit at byte addresses 0 (reply
// timeout), 4 (fault step) and 8 (fault limit) and must be written only
// while the block is idle.
module robot_link_mode_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [2:0]          in_requested_mode,
  input  logic signed [15:0]  in_distance_delta,
  input  logic signed [15:0]  in_angle_delta,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_action,
  output logic [2:0]          out_mode,
  output logic                out_link_up,
  output logic signed [31:0]  out_distance_sum,
  output logic signed [31:0]  out_angle_sum,
  output logic [7:0]          out_fault_count,
  output logic                out_last,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import rlmc_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      cfg_wr;
  logic [1:0] cfg_idx;
  q_status_t qstat;
  q_entry_t  push_data, head;
  logic      push, pop;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        CFG_TIMEOUT: cfg_nxt.reply_timeout_ticks = cfg_pwdata[7:0];
        CFG_STEP:    cfg_nxt.fault_step          = cfg_pwdata[7:0];
        CFG_LIMIT:   cfg_nxt.fault_limit         = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_TIMEOUT: cfg_prdata = {24'd0, cfg_r.reply_timeout_ticks};
      CFG_STEP:    cfg_prdata = {24'd0, cfg_r.fault_step};
      CFG_LIMIT:   cfg_prdata = {24'd0, cfg_r.fault_limit};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reply_timeout_ticks <= TIMEOUT_RST;
      cfg_r.fault_step          <= STEP_RST;
      cfg_r.fault_limit         <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rlmc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_requested_mode (in_requested_mode),
    .in_distance_delta (in_distance_delta),
    .in_angle_delta    (in_angle_delta),
    .qstat             (qstat),
    .push              (push),
    .push_data         (push_data)
  );

  rlmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  rlmc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .qstat            (qstat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_mode         (out_mode),
    .out_link_up      (out_link_up),
    .out_distance_sum (out_distance_sum),
    .out_angle_sum    (out_angle_sum),
    .out_fault_count  (out_fault_count),
    .out_last         (out_last)
  );

endmodule

FILE: test/robot_link_mode_controller_tb.sv
`timescale 1ns / 1ps
module robot_link_mode_controller_tb;
  import rlmc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [2:0] R_UNUSED = 3'd7;
  localparam int MAX_CMDS = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  mode;
    logic        link_up;
    logic [31:0] distance_sum;
    logic [31:0] angle_sum;
    logic [7:0]  fault_count;
    logic        last;
  } link_result_t;

  class link_ctrl_scoreboard;
    logic [7:0] timeout_ticks;
    logic [7:0] step_size;
    logic [7:0] limit;
    logic [2:0] mode_q;
    logic [2:0] init_step;
    logic [2:0] pending_req;
    logic awaiting;
    logic link;
    logic fresh;
    logic [7:0] countdown;
    logic [7:0] faults;
    logic [31:0] dist_acc;
    logic [31:0] ang_acc;
    int n_cmds;
    int errors;
    link_result_t predicted_results[$];

    function new();
      timeout_ticks = TIMEOUT_RST;
      step_size = STEP_RST;
      limit = LIMIT_RST;
      mode_q = M_INIT;
      init_step = '0;
      pending_req = R_NONE;
      awaiting = 1'b0;
      link = 1'b0;
      fresh = 1'b0;
      countdown = '0;
      faults = '0;
      dist_acc = '0;
      ang_acc = '0;
      n_cmds = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_TIMEOUT: timeout_ticks = value;
        CFG_STEP:    step_size = value;
        CFG_LIMIT:   limit = value;
        default: ;
      endcase
    endfunction

    function void issue(logic [3:0] act);
      link_result_t r;
      if (n_cmds < MAX_CMDS) begin
        r = '0;
        r.action = act;
        predicted_results.push_back(r);
        n_cmds++;
      end
    endfunction

    function void request_sensor();
      if (!awaiting) begin
        awaiting = 1'b1;
        countdown = timeout_ticks;
        issue(A_SENSOR);
      end
    endfunction

    function void enter_mode(logic [2:0] m);
      init_step = '0;
      pending_req = R_NONE;
      mode_q = m;
    endfunction

    function void drop_power();
      link = 1'b0;
      issue(A_POWER);
      enter_mode(M_OFF);
    endfunction

    function void advance_tick();
      logic [2:0] p;
      logic [8:0] total;
      p = pending_req;
      if (countdown != 0) begin
        countdown = countdown - 8'd1;
        if (countdown == 0) begin
          total = {1'b0, faults} + {1'b0, step_size};
          awaiting = 1'b0;
          faults = total[8] ? 8'hFF : total[7:0];
        end
      end
      if (p == R_RESET) begin
        issue(A_RESET);
        enter_mode(M_ON);
        p = R_NONE;
      end
      if (faults >= limit) begin
        link = 1'b0;
        issue(A_POWER);
        init_step = '0;
      end
      case (mode_q)
        M_INIT: begin
          case (init_step)
            3'd0: begin
              issue(A_START);
              init_step = 3'd1;
            end
            3'd1: begin
              request_sensor();
              fresh = 1'b0;
              init_step = 3'd2;
            end
            3'd2, 3'd3, 3'd4: begin
              init_step = init_step + 3'd1;
              if (fresh) begin
                init_step = '0;
                mode_q = M_ON;
                faults = '0;
                link = 1'b1;
              end
            end
            3'd5: drop_power();
            default: ;
          endcase
        end
        M_ON: begin
          if (p == R_ON) pending_req = R_NONE;
          else if (p == R_OFF) drop_power();
          else if (p == R_CLEAN) begin
            issue(A_CLEAN);
            enter_mode(M_CLEAN);
          end else if (p == R_MAX) begin
            issue(A_MAX);
            enter_mode(M_CLEAN);
          end else if (p == R_DOCK) begin
            issue(A_DOCK);
            enter_mode(M_DOCK);
          end
        end
        M_OFF: begin
          if (p == R_OFF) pending_req = R_NONE;
          else if (p == R_ON || p == R_CLEAN || p == R_MAX || p == R_DOCK) mode_q = M_WAKEHI;
        end
        M_CLEAN: begin
          if (p == R_OFF) drop_power();
          else if (p == R_ON) begin
            issue(A_CLEAN);
            enter_mode(M_ON);
          end else if (p == R_MAX) begin
            issue(A_MAX);
            issue(A_MAX);
            enter_mode(M_CLEAN);
          end else if (p == R_DOCK) begin
            issue(A_DOCK);
            issue(A_DOCK);
            enter_mode(M_DOCK);
          end else if (p == R_CLEAN) pending_req = R_NONE;
        end
        M_DOCK: begin
          if (p == R_OFF) drop_power();
          else if (p == R_ON) begin
            issue(A_DOCK);
            enter_mode(M_ON);
          end else if (p == R_MAX) begin
            issue(A_MAX);
            issue(A_MAX);
            enter_mode(M_CLEAN);
          end else if (p == R_CLEAN) begin
            issue(A_CLEAN);
            issue(A_CLEAN);
            enter_mode(M_CLEAN);
          end else if (p == R_DOCK) pending_req = R_NONE;
        end
        M_WAKEHI: begin
          issue(A_WAKEHI);
          mode_q = M_WAKELO;
        end
        M_WAKELO: begin
          issue(A_WAKELO);
          init_step = '0;
          mode_q = M_INIT;
        end
        default: mode_q = M_INIT;
      endcase
      if (link) request_sensor();
      else begin
        dist_acc = '0;
        ang_acc = '0;
      end
    endfunction

    function void note_item(logic [1:0] op, logic [2:0] req, logic signed [15:0] dd,
                            logic signed [15:0] ad);
      link_result_t r;
      n_cmds = 0;
      case (op)
        OP_TICK: advance_tick();
        OP_REQ: begin
          if (mode_q >= M_OFF && mode_q <= M_CLEAN) pending_req = req;
          else pending_req = R_NONE;
        end
        OP_PKT: begin
          if (awaiting) begin
            dist_acc = dist_acc - {{16{dd[15]}}, dd};
            ang_acc = ang_acc + {{16{ad[15]}}, ad};
            awaiting = 1'b0;
            countdown = '0;
            fresh = 1'b1;
            if (faults != 0) faults = faults - 8'd1;
          end
        end
        default: ;
      endcase
      r.action = A_STATUS;
      r.mode = mode_q;
      r.link_up = link;
      r.distance_sum = dist_acc;
      r.angle_sum = ang_acc;
      r.fault_count = faults;
      r.last = 1'b1;
      predicted_results.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [3:0] action, logic [2:0] mode, logic link_up,
                               logic [31:0] dsum, logic [31:0] asum, logic [7:0] fault,
                               logic last);
      link_result_t want;
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got action %0d", $time, action);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        compare("action", want.action, action);
        compare("mode", want.mode, mode);
        compare("link_up", want.link_up, link_up);
        compare("distance_sum", want.distance_sum, dsum);
        compare("angle_sum", want.angle_sum, asum);
        compare("fault_count", want.fault_count, fault);
        compare("last", want.last, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic [2:0] in_requested_mode = '0;
  logic signed [15:0] in_distance_delta = '0;
  logic signed [15:0] in_angle_delta = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_action;
  logic [2:0] out_mode;
  logic out_link_up;
  logic signed [31:0] out_distance_sum;
  logic signed [31:0] out_angle_sum;
  logic [7:0] out_fault_count;
  logic out_last;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  link_ctrl_scoreboard sb;
  int sender_idle_pct = 30;
  int receiver_idle_pct = 65;
  int cfg_errors = 0;
  int stall_cycles = 0;

  robot_link_mode_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_requested_mode(in_requested_mode),
    .in_distance_delta(in_distance_delta),
    .in_angle_delta(in_angle_delta),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_action(out_action),
    .out_mode(out_mode),
    .out_link_up(out_link_up),
    .out_distance_sum(out_distance_sum),
    .out_angle_sum(out_angle_sum),
    .out_fault_count(out_fault_count),
    .out_last(out_last),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= (receiver_idle_pct == 0) || ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_item(in_op, in_requested_mode, in_distance_delta, in_angle_delta);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_action, out_mode, out_link_up, out_distance_sum, out_angle_sum,
                      out_fault_count, out_last);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("robot_link_mode_controller_tb failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_request();
    if ($urandom_range(99) < 5) return R_UNUSED;
    return 3'($urandom_range(6));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [2:0] req,
                           input logic signed [15:0] dd, input logic signed [15:0] ad);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_requested_mode <= req;
    in_distance_delta <= dd;
    in_angle_delta <= ad;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic tick_item();
    send_item(OP_TICK, 3'($urandom), rand_delta(), rand_delta());
  endtask

  task automatic request_item(input logic [2:0] req);
    send_item(OP_REQ, req, rand_delta(), rand_delta());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[7:0] !== value) begin
      $display("%0t: readback of register %0d, expected %0h, got %0h", $time, idx, value,
               cfg_prdata[7:0]);
      cfg_errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] timeout, input logic [7:0] step,
                           input logic [7:0] lim, input int send_pct, input int recv_pct);
    wait_drained();
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_STEP, step);
    write_reg(CFG_LIMIT, lim);
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
  endtask

  // mostly ticks and replies to outstanding polls, with requests mixed in
  task automatic run_random(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (sb.awaiting && pick < 30) send_item(OP_PKT, 3'($urandom), rand_delta(), rand_delta());
      else if (pick < 62) tick_item();
      else if (pick < 86) request_item(rand_request());
      else if (pick < 95) send_item(OP_PKT, 3'($urandom), rand_delta(), rand_delta());
      else send_item(OP_NONE, 3'($urandom), rand_delta(), rand_delta());
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bring the link up, then walk the mode transitions
    send_item(OP_NONE, R_UNUSED, 16'sh7FFF, 16'sh8000);
    request_item(R_ON);
    send_item(OP_PKT, R_NONE, 16'sh8000, 16'sh7FFF);
    tick_item();
    tick_item();
    send_item(OP_PKT, R_NONE, 16'sh8000, 16'sh7FFF);
    tick_item();
    send_item(OP_PKT, R_NONE, 16'sh7FFF, 16'sh8000);
    request_item(R_CLEAN);
    tick_item();
    request_item(R_MAX);
    tick_item();
    request_item(R_DOCK);
    tick_item();
    request_item(R_CLEAN);
    tick_item();
    request_item(R_ON);
    tick_item();
    request_item(R_UNUSED);
    tick_item();
    request_item(R_RESET);
    tick_item();
    request_item(R_OFF);
    tick_item();
    request_item(R_DOCK);
    repeat (4) tick_item();

    run_random(50);
    configure(8'd1, 8'd255, 8'd255, 30, 65);
    run_random(45);
    configure(8'd255, 8'd0, 8'd1, 65, 30);
    run_random(45);
    configure(8'd0, 8'd128, 8'd0, 65, 30);
    run_random(35);
    configure(8'($urandom_range(1, 6)), 8'($urandom_range(0, 255)),
              8'($urandom_range(1, 255)), 0, 0);
    run_random(55);
    configure(8'd3, 8'd40, 8'd100, 0, 0);
    run_random(40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && cfg_errors == 0) begin
      $display("robot_link_mode_controller_tb passed");
    end else begin
      $display("robot_link_mode_controller_tb failed");
    end
    $finish;
  end

endmodule
